FILE: src/sha1c_pkg.sv
// Shared types, constants and helper functions for the SHA-1 compression block.
// It depends on nothing else. Every module in src imports it.
package sha1c_pkg;

  // Sizes of the algorithm.
  localparam int ROUNDS    = 80;
  localparam int WORD_W    = 32;
  localparam int NUM_H     = 5;
  localparam int WIN_DEPTH = 16;
  localparam int GRP_LEN   = ROUNDS / 4;
  localparam int ROUND_W   = $clog2(ROUNDS);
  localparam int WCNT_W    = $clog2(WIN_DEPTH);
  localparam int IDX_W     = $clog2(NUM_H);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [1:0]        grp_t;

  // Round groups, 20 rounds each.
  localparam grp_t GRP_CH   = 2'd0;
  localparam grp_t GRP_PAR1 = 2'd1;
  localparam grp_t GRP_MAJ  = 2'd2;
  localparam grp_t GRP_PAR2 = 2'd3;

  // Control to the message schedule window.
  typedef struct packed {
    logic load;  // shift in one message word
    logic step;  // shift by one round, appending the expanded word
  } sched_ctrl_t;

  // Control to the round unit and chaining value.
  typedef struct packed {
    logic load_iv;  // reload the standard initial value
    logic start;    // copy the chaining value into the working variables
    logic step;     // run one round
    logic add;      // add the working variables into the chaining value
  } round_ctrl_t;

  // Round constant of a group.
  function automatic word_t round_k(grp_t g);
    word_t k;
    case (g)
      GRP_CH:   k = 32'h5a827999;
      GRP_PAR1: k = 32'h6ed9eba1;
      GRP_MAJ:  k = 32'h8f1bbcdc;
      default:  k = 32'hca62c1d6;
    endcase
    return k;
  endfunction

  // Standard initial hash value, word 0 is A.
  function automatic word_t init_h(logic [IDX_W-1:0] i);
    word_t h;
    case (i)
      3'd0:    h = 32'h67452301;
      3'd1:    h = 32'hefcdab89;
      3'd2:    h = 32'h98badcfe;
      3'd3:    h = 32'h10325476;
      default: h = 32'hc3d2e1f0;
    endcase
    return h;
  endfunction

endpackage

FILE: src/sha1c_sched.sv
// Message schedule window of the SHA-1 block: a 16-word shift line.
// Depends on sha1c_pkg.
module sha1c_sched (
  input  logic                    clk,
  input  sha1c_pkg::sched_ctrl_t  ctl,
  input  sha1c_pkg::word_t        word_in,
  output sha1c_pkg::word_t        w_out
);
  import sha1c_pkg::*;

  word_t win [WIN_DEPTH];
  word_t expand;

  // Entry 0 always holds the word of the current round; the word needed
  // sixteen rounds later is built from the fixed taps.
  always_comb begin
    expand = win[13] ^ win[8] ^ win[2] ^ win[0];
    expand = {expand[WORD_W-2:0], expand[WORD_W-1]};
  end

  assign w_out = win[0];

  // Shift in message words while loading, expanded words while hashing.
  always_ff @(posedge clk) begin
    if (ctl.load || ctl.step) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[WIN_DEPTH-1] <= ctl.load ? word_in : expand;
    end
  end

endmodule

FILE: src/sha1c_round.sv
// SHA-1 round unit: working variables, the shared round adder and the
// chaining value. Depends on sha1c_pkg.
module sha1c_round (
  input  logic                    clk,
  input  logic                    rst,
  input  sha1c_pkg::round_ctrl_t  ctl,
  input  sha1c_pkg::grp_t         grp,
  input  sha1c_pkg::word_t        w,
  output sha1c_pkg::word_t        chain [sha1c_pkg::NUM_H]
);
  import sha1c_pkg::*;

  word_t wv [NUM_H];
  word_t f;
  word_t t;

  // Round function of the current group, then the round sum.
  always_comb begin
    case (grp)
      GRP_CH:  f = (wv[1] & wv[2]) | (~wv[1] & wv[3]);
      GRP_MAJ: f = (wv[1] & wv[2]) | (wv[1] & wv[3]) | (wv[2] & wv[3]);
      default: f = wv[1] ^ wv[2] ^ wv[3];
    endcase
    t = {wv[0][WORD_W-6:0], wv[0][WORD_W-1:WORD_W-5]} + f + wv[4] + round_k(grp) + w;
  end

  // Working variables: loaded from the chaining value, then one round a cycle.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < NUM_H; i++) begin
        wv[i] <= chain[i];
      end
    end else if (ctl.step) begin
      wv[4] <= wv[3];
      wv[3] <= wv[2];
      wv[2] <= {wv[1][1:0], wv[1][WORD_W-1:2]};
      wv[1] <= wv[0];
      wv[0] <= t;
    end
  end

  // Chaining value: initial value on reset or on a new message.
  always_ff @(posedge clk) begin
    if (rst || ctl.load_iv) begin
      for (int i = 0; i < NUM_H; i++) begin
        chain[i] <= init_h(IDX_W'(i));
      end
    end else if (ctl.add) begin
      for (int i = 0; i < NUM_H; i++) begin
        chain[i] <= chain[i] + wv[i];
      end
    end
  end

endmodule

FILE: src/sha1_compression_top.sv
// Top level of the SHA-1 compression block: sequencer and stream ports.
// Depends on sha1c_pkg, sha1c_sched and sha1c_round.
//
// The block takes one padded 32-bit message word per cycle while s_tready is
// high. The sixteenth word of a block starts the compression, which runs one
// round per cycle on a single round adder: the rounds, then the add into the
// chaining value, during which s_tready is low, so the next block's words
// wait until the add is done. When the block was marked as last, the five
// digest words (A first) follow on the master side, one per accepted
// transaction, and input resumes after the fifth. first_block on the first
// word of a block reloads the standard initial value; without it a block
// continues from the current hash.
module sha1_compression_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // msg_word
  input  logic [1:0]  s_tuser,   // first_block, last_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [2:0]  m_tuser,   // digest_index
  output logic        m_tlast    // digest_last
);
  import sha1c_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_ADD   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t             state;
  logic [WCNT_W-1:0]  word_cnt;
  logic [ROUND_W-1:0] round_cnt;
  logic [IDX_W-1:0]   out_idx;
  logic               last_flag;
  logic               in_acc;
  logic               out_acc;
  logic               block_done;
  grp_t               grp;
  sched_ctrl_t        sctl;
  round_ctrl_t        rctl;
  word_t              w;
  word_t              chain [NUM_H];

  assign s_tready   = (state == S_IDLE);
  assign in_acc     = s_tvalid && s_tready;
  assign m_tvalid   = (state == S_OUT);
  assign out_acc    = m_tvalid && m_tready;
  assign block_done = in_acc && (word_cnt == WCNT_W'(WIN_DEPTH - 1));

  // Round group from the round counter.
  always_comb begin
    if (round_cnt < ROUND_W'(GRP_LEN)) begin
      grp = GRP_CH;
    end else if (round_cnt < ROUND_W'(2 * GRP_LEN)) begin
      grp = GRP_PAR1;
    end else if (round_cnt < ROUND_W'(3 * GRP_LEN)) begin
      grp = GRP_MAJ;
    end else begin
      grp = GRP_PAR2;
    end
  end

  // Control to the datapath.
  always_comb begin
    sctl.load    = in_acc;
    sctl.step    = (state == S_ROUND);
    rctl.load_iv = in_acc && (word_cnt == '0) && s_tuser[0];
    rctl.start   = block_done;
    rctl.step    = (state == S_ROUND);
    rctl.add     = (state == S_ADD);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      word_cnt  <= '0;
      round_cnt <= '0;
      out_idx   <= '0;
      last_flag <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            word_cnt <= word_cnt + 1'b1;
          end
          if (block_done) begin
            state     <= S_ROUND;
            round_cnt <= '0;
            last_flag <= s_tuser[1];
          end
        end
        S_ROUND: begin
          if (round_cnt == ROUND_W'(ROUNDS - 1)) begin
            state     <= S_ADD;
            round_cnt <= '0;
          end else begin
            round_cnt <= round_cnt + 1'b1;
          end
        end
        S_ADD: begin
          out_idx <= '0;
          state   <= last_flag ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          if (out_acc) begin
            if (out_idx == IDX_W'(NUM_H - 1)) begin
              state <= S_IDLE;
            end else begin
              out_idx <= out_idx + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Digest words come straight from the chaining value, held during output.
  assign m_tdata = chain[out_idx];
  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == IDX_W'(NUM_H - 1));

  sha1c_sched u_sched (
    .clk     (clk),
    .ctl     (sctl),
    .word_in (s_tdata),
    .w_out   (w)
  );

  sha1c_round u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl   (rctl),
    .grp   (grp),
    .w     (w),
    .chain (chain)
  );

  // The sixteenth word of a block always starts the rounds at round zero.
  a_block_start: assert property (@(posedge clk) disable iff (rst)
    block_done |=> (state == S_ROUND) && (round_cnt == '0))
    else $error("block completion did not start the rounds");

  // The last round is always followed by the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) && (round_cnt == ROUND_W'(ROUNDS - 1)) |=> (state == S_ADD))
    else $error("rounds did not end in the chaining add");

  // The digest index never runs past the last word.
  a_out_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_idx < IDX_W'(NUM_H)))
    else $error("digest index out of range");

  // Taking the last digest word reopens the input.
  a_out_done: assert property (@(posedge clk) disable iff (rst)
    out_acc && m_tlast |=> s_tready && !m_tvalid)
    else $error("input not reopened after digest");

  // Input and output never run at the same time.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output open together");

endmodule
